// ----- hdl/amhg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Acceleration magnitude hold gate: shared definitions
// Types, register codes and reset constants used by every block file.
// ----------------------------------------------------------------------------
package amhg_pkg;

    localparam int AXIS_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 32;
    localparam int THR_SQ_W = 2 * CFG_W;
    localparam int IDX_W    = 2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd10240;
    localparam logic [CFG_W-1:0] HOLD_RST      = 16'd300;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd10000;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RST =
        THR_SQ_W'(32'd10240 * 32'd10240);

    typedef enum logic [IDX_W-1:0] {
        REG_MAG_THRESHOLD = 2'd0,
        REG_HOLD_DURATION = 2'd1,
        REG_QUEUE_TIMEOUT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [THR_SQ_W-1:0] thr_sq;
        logic [CFG_W-1:0]    hold_ms;
        logic [CFG_W-1:0]    timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [SQ_W-1:0]   sq_x;
        logic [SQ_W-1:0]   sq_y;
        logic [SQ_W-1:0]   sq_z;
        logic [TIME_W-1:0] time_ms;
    } t_mag_item;

endpackage
`default_nettype wire

// ----- hdl/amhg_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the hold time and queue timeout, and keeps the threshold only as its
// square in a register of its own so that the compare needs no multiplier.
// ----------------------------------------------------------------------------
module amhg_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [amhg_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [amhg_pkg::CFG_W-1:0]  i_cfg_data,
    output amhg_pkg::t_cfg                   o_cfg
);
    import amhg_pkg::*;

    logic [CFG_W-1:0]    r_hold;
    logic [CFG_W-1:0]    r_timeout;
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic [THR_SQ_W-1:0] n_thr_sq;

    assign o_cfg_ready = 1'b1;
    assign n_thr_sq    = THR_SQ_W'(i_cfg_data) * THR_SQ_W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq  <= THR_SQ_RST;
            r_hold    <= HOLD_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAG_THRESHOLD: r_thr_sq  <= n_thr_sq;
                REG_HOLD_DURATION: r_hold    <= i_cfg_data;
                REG_QUEUE_TIMEOUT: r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.thr_sq     = r_thr_sq;
    assign o_cfg.hold_ms    = r_hold;
    assign o_cfg.timeout_ms = r_timeout;

endmodule
`default_nettype wire

// ----- hdl/amhg_mag_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample register and squaring stage
// Registers the incoming sample, then registers the three axis squares.
// ----------------------------------------------------------------------------
module amhg_mag_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_x,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_y,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_z,
    input  wire logic [amhg_pkg::TIME_W-1:0]  i_sample_time_ms,
    output logic                              o_item_valid,
    input  wire logic                         i_item_ready,
    output amhg_pkg::t_mag_item               o_item
);
    import amhg_pkg::*;

    logic                      r_v1;
    logic signed [AXIS_W-1:0]  r_x;
    logic signed [AXIS_W-1:0]  r_y;
    logic signed [AXIS_W-1:0]  r_z;
    logic [TIME_W-1:0]         r_t1;
    logic                      r_v2;
    t_mag_item                 r_item;
    logic                      w_s2_ready;
    logic signed [2*AXIS_W-1:0] w_px;
    logic signed [2*AXIS_W-1:0] w_py;
    logic signed [2*AXIS_W-1:0] w_pz;

    assign w_s2_ready = !r_v2 || i_item_ready;
    assign o_ready    = !r_v1 || w_s2_ready;

    assign w_px = r_x * r_x;
    assign w_py = r_y * r_y;
    assign w_pz = r_z * r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (w_s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x  <= i_accel_x;
            r_y  <= i_accel_y;
            r_z  <= i_accel_z;
            r_t1 <= i_sample_time_ms;
        end
        if (w_s2_ready && r_v1) begin
            r_item.sq_x    <= w_px[SQ_W-1:0];
            r_item.sq_y    <= w_py[SQ_W-1:0];
            r_item.sq_z    <= w_pz[SQ_W-1:0];
            r_item.time_ms <= r_t1;
        end
    end

    assign o_item_valid = r_v2;
    assign o_item       = r_item;

endmodule
`default_nettype wire

// ----- hdl/amhg_hold_logic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Threshold compare, hold timer and queued flag
// Sums the squares, compares with the squared threshold, updates the gate
// state and registers the result for the output channel.
// ----------------------------------------------------------------------------
module amhg_hold_logic (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire amhg_pkg::t_cfg  i_cfg,
    input  wire logic            i_item_valid,
    output logic                 o_item_ready,
    input  wire amhg_pkg::t_mag_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_trigger,
    output logic                 o_queued
);
    import amhg_pkg::*;

    logic              r_above;
    logic [TIME_W-1:0] r_since;
    logic [TIME_W-1:0] r_last_peak;
    logic              r_queued;
    logic              r_out_valid;
    logic              r_trig;
    logic              r_q_out;
    logic              n_above;
    logic [TIME_W-1:0] n_since;
    logic [TIME_W-1:0] n_last_peak;
    logic              n_queued;
    logic              n_trig;
    logic              w_take;
    logic              w_exceeds;
    logic              w_q_kept;
    logic [SUM_W-1:0]  w_sum;
    logic [TIME_W-1:0] w_d_peak;
    logic [TIME_W-1:0] w_d_since;

    assign o_item_ready = !r_out_valid || i_ready;
    assign w_take       = i_item_valid && o_item_ready;

    always_comb begin
        w_sum     = SUM_W'(i_item.sq_x) + SUM_W'(i_item.sq_y) + SUM_W'(i_item.sq_z);
        w_exceeds = w_sum >= i_cfg.thr_sq;
        w_d_peak  = i_item.time_ms - r_last_peak;
        w_d_since = i_item.time_ms - r_since;
        w_q_kept  = r_queued && !(w_d_peak > TIME_W'(i_cfg.timeout_ms));
        if (w_exceeds) begin
            n_above     = 1'b1;
            n_since     = r_above ? r_since : i_item.time_ms;
            n_last_peak = i_item.time_ms;
            n_trig      = r_above && (w_d_since > TIME_W'(i_cfg.hold_ms));
        end else begin
            n_above     = 1'b0;
            n_since     = i_item.time_ms;
            n_last_peak = r_last_peak;
            n_trig      = 1'b0;
        end
        n_queued = w_q_kept || n_trig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above     <= 1'b0;
            r_since     <= '0;
            r_last_peak <= '0;
            r_queued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_above     <= n_above;
                r_since     <= n_since;
                r_last_peak <= n_last_peak;
                r_queued    <= n_queued;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_trig  <= n_trig;
            r_q_out <= n_queued;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_trigger = r_trig;
    assign o_queued  = r_q_out;

endmodule
`default_nettype wire

// ----- hdl/accel_magnitude_hold_gate_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Acceleration magnitude hold gate
// Decides per accelerometer sample whether a downstream classifier runs.
// ----------------------------------------------------------------------------
// Each request on the sample channel carries signed Q4.12 x, y and z values
// and a millisecond timestamp. Each sample gives exactly one result request
// with a trigger bit and the queued flag after that sample's update.
// The sample is registered, the three squares are registered, and the sum is
// compared with the squared threshold while the hold and timeout state is
// updated into the result register. One sample is accepted every cycle
// while the receiver does not stall, set by the single state update stage.
// The configuration channel is always ready and writes one register per
// request; index 0 is the threshold, 1 the hold time, 2 the queue timeout,
// and any other index is ignored. A threshold write stores only its square.
// Reset empties the pipeline, clears the gate state and loads the register
// defaults. When the receiver stalls, the result holds and the pipeline
// keeps filling until all three stages are full, then o_ready drops.
// ----------------------------------------------------------------------------
module accel_magnitude_hold_gate_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_x,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_y,
    input  wire logic [amhg_pkg::AXIS_W-1:0]  i_accel_z,
    input  wire logic [amhg_pkg::TIME_W-1:0]  i_sample_time_ms,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_trigger,
    output logic                              o_queued,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [amhg_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [amhg_pkg::CFG_W-1:0]   i_cfg_data
);
    import amhg_pkg::*;

    t_cfg      w_cfg;
    t_mag_item w_item;
    logic      w_item_valid;
    logic      w_item_ready;

    amhg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    amhg_mag_stage u_mag (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_sample_time_ms (i_sample_time_ms),
        .o_item_valid     (w_item_valid),
        .i_item_ready     (w_item_ready),
        .o_item           (w_item)
    );

    amhg_hold_logic u_hold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_trigger    (o_trigger),
        .o_queued     (o_queued)
    );

endmodule
`default_nettype wire

// ----- hdl/amhg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the acceleration magnitude hold gate
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module amhg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_trigger,
    input wire logic o_queued
);

    // A trigger always sets the queued flag on the same result.
    a_trigger_sets_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_trigger || o_queued))
        else $error("trigger reported without queued flag");

    // Reset empties the pipeline, so no result shows in the next cycle.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    // A stalled result stays on the port.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_trigger) && $stable(o_queued)))
        else $error("stalled result changed or vanished");

    // With the output empty, the sample side can never be stalled.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !$past(i_valid)) |-> o_ready)
        else $error("sample channel stalled with empty output");

endmodule

bind accel_magnitude_hold_gate_unit amhg_checker u_amhg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_trigger (o_trigger),
    .o_queued  (o_queued)
);
`default_nettype wire
